[src/svmsc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stereo voice mixer with soft clip.
// No dependencies; every other file refers to this package by scoped names.
package svmsc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 9;
  // Signed sample times zero-extended gain.
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W    = 32;
  localparam int THRESH_W = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE           = 8'd1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd28000;

  typedef struct packed {
    logic [THRESH_W-1:0] clip_threshold;
    logic                mute;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic frame_valid;
    logic accum_zero;
  } back_status_t;

endpackage

[src/svmsc_front.sv]
`timescale 1ns / 1ps
// Front end: takes voice transactions, scales both samples by their gains
// and hands the shifted contributions to the queue. Uses svmsc_pkg.
module svmsc_front #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int CONTRIB_W      = 25 - GAIN_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [svmsc_pkg::SAMPLE_W-1:0]  left_sample,
  input  logic signed [svmsc_pkg::SAMPLE_W-1:0]  right_sample,
  input  logic [svmsc_pkg::GAIN_W-1:0]           left_level,
  input  logic [svmsc_pkg::GAIN_W-1:0]           right_level,
  input  logic                                   last,
  input  svmsc_pkg::q_status_t                   q_stat,
  output logic                                   q_wr_en,
  output logic [2*CONTRIB_W:0]                   q_wr_data
);

  logic signed [svmsc_pkg::PROD_W-1:0] l_prod;
  logic signed [svmsc_pkg::PROD_W-1:0] r_prod;
  logic                                p_valid;
  logic [2*CONTRIB_W:0]                p_data;
  logic                                advance;

  // The arithmetic shift is a bit-select; the bits above fit the contribution.
  assign l_prod = $signed(left_sample) * $signed({1'b0, left_level});
  assign r_prod = $signed(right_sample) * $signed({1'b0, right_level});

  assign advance   = p_valid && !q_stat.full;
  assign in_ready  = !p_valid || !q_stat.full;
  assign q_wr_en   = advance;
  assign q_wr_data = p_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      p_valid <= 1'b1;
    end else if (advance) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_data <= {l_prod[GAIN_FRAC_BITS +: CONTRIB_W], r_prod[GAIN_FRAC_BITS +: CONTRIB_W], last};
    end
  end

endmodule

[src/svmsc_fifo.sv]
`timescale 1ns / 1ps
// Short queue that decouples the front end from the accumulator.
// Register based, one write and one head read per cycle. Uses svmsc_pkg.
module svmsc_fifo #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  output logic [WIDTH-1:0]     rd_data,
  output svmsc_pkg::q_status_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

[src/svmsc_back.sv]
`timescale 1ns / 1ps
// Back end: saturating accumulation of queued contributions, frame capture
// on the last voice, soft clip, clamp and mute into the output register.
// Uses svmsc_pkg.
module svmsc_back #(
  parameter int CONTRIB_W = 17
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  svmsc_pkg::cfg_t                       cfg,
  input  svmsc_pkg::q_status_t                  q_stat,
  input  logic [2*CONTRIB_W:0]                  q_rd_data,
  output logic                                  q_rd_en,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [svmsc_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [svmsc_pkg::SAMPLE_W-1:0] right_out,
  output svmsc_pkg::back_status_t               stat
);

  localparam int AW = svmsc_pkg::ACC_W;

  logic signed [CONTRIB_W-1:0] head_l;
  logic signed [CONTRIB_W-1:0] head_r;
  logic                        head_last;
  logic [AW-1:0]               left_accum;
  logic [AW-1:0]               right_accum;
  logic [AW-1:0]               left_sum;
  logic [AW-1:0]               right_sum;
  logic [AW-1:0]               frame_l;
  logic [AW-1:0]               frame_r;
  logic                        frame_valid;
  logic                        out_free;
  logic                        frame_free;
  logic                        frame_move;
  logic [svmsc_pkg::SAMPLE_W-1:0] left_clip;
  logic [svmsc_pkg::SAMPLE_W-1:0] right_clip;

  function automatic logic [AW-1:0] sat_add(logic [AW-1:0] acc, logic [CONTRIB_W-1:0] c);
    logic [AW:0] sum;
    sum = {acc[AW-1], acc} + {{(AW + 1 - CONTRIB_W){c[CONTRIB_W-1]}}, c};
    if (sum[AW] != sum[AW-1]) begin
      sat_add = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      sat_add = sum[AW-1:0];
    end
  endfunction

  // Works on the magnitude; the compressed excess is floored, then the
  // magnitude is clamped to 32767 (positive) or 32768 (negative).
  function automatic logic [svmsc_pkg::SAMPLE_W-1:0] compress_sample(
    logic [AW-1:0] s, logic [svmsc_pkg::THRESH_W-1:0] t);
    logic          neg;
    logic [AW:0]   mag;
    logic [AW:0]   thr;
    logic [AW:0]   cmp;
    logic [AW:0]   lim;
    neg = s[AW-1];
    mag = neg ? (~{s[AW-1], s} + (AW+1)'(1)) : {s[AW-1], s};
    thr = (AW+1)'(t);
    if (mag > thr) begin
      cmp = thr + ((mag - thr) >> 2);
    end else begin
      cmp = mag;
    end
    lim = neg ? (AW+1)'(32768) : (AW+1)'(32767);
    if (cmp > lim) begin
      cmp = lim;
    end
    compress_sample = neg ? (~cmp[svmsc_pkg::SAMPLE_W-1:0] + svmsc_pkg::SAMPLE_W'(1))
                          : cmp[svmsc_pkg::SAMPLE_W-1:0];
  endfunction

  assign head_l    = q_rd_data[2*CONTRIB_W -: CONTRIB_W];
  assign head_r    = q_rd_data[CONTRIB_W:1];
  assign head_last = q_rd_data[0];

  assign out_free   = !out_valid || out_ready;
  assign frame_move = frame_valid && out_free;
  assign frame_free = !frame_valid || out_free;
  // Non-final voices never wait on the output side.
  assign q_rd_en    = !q_stat.empty && (!head_last || frame_free);

  assign left_sum  = sat_add(left_accum, head_l);
  assign right_sum = sat_add(right_accum, head_r);

  assign left_clip  = compress_sample(frame_l, cfg.clip_threshold);
  assign right_clip = compress_sample(frame_r, cfg.clip_threshold);

  assign stat.frame_valid = frame_valid;
  assign stat.accum_zero  = (left_accum == '0) && (right_accum == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_accum  <= '0;
      right_accum <= '0;
      frame_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_rd_en) begin
        if (head_last) begin
          left_accum  <= '0;
          right_accum <= '0;
        end else begin
          left_accum  <= left_sum;
          right_accum <= right_sum;
        end
      end
      if (q_rd_en && head_last) begin
        frame_valid <= 1'b1;
      end else if (frame_move) begin
        frame_valid <= 1'b0;
      end
      if (frame_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en && head_last) begin
      frame_l <= left_sum;
      frame_r <= right_sum;
    end
    if (frame_move) begin
      left_out  <= cfg.mute ? '0 : $signed(left_clip);
      right_out <= cfg.mute ? '0 : $signed(right_clip);
    end
  end

endmodule

[src/stereo_voice_mix_soft_clip_core.sv]
`timescale 1ns / 1ps
// Stereo voice mixer with soft clip, top level.
// Depends on svmsc_pkg, svmsc_front, svmsc_fifo and svmsc_back.
//
// Each input transaction carries one voice: a signed stereo sample pair and
// unsigned left and right gains with GAIN_FRAC_BITS fraction bits. Each
// sample is scaled by its gain, shifted right arithmetically and added into
// a saturating 32-bit accumulator per side. A transaction with last set
// closes the frame: one output transaction carries both sums after soft
// clipping (a quarter of the excess over clip_threshold is kept) and a clamp
// to 16 bits, or zeros while mute is set. The accumulators then restart.
// One voice is accepted per cycle while in_ready is high. After its last
// voice is accepted, a frame passes from the product register into the
// queue, from the queue into the accumulator and frame register, and
// through the clip into the output register.
// The output register holds its transaction while out_ready is low; the
// frame register and a four-entry queue keep voices flowing meanwhile, and
// in_ready drops only once the queue and the product register are full.
// Configuration writes (index 0: clip_threshold, 1: mute) are always taken
// and belong in idle periods. Reset empties the pipeline, zeroes both
// accumulators, sets the threshold to 28000 and clears mute.
module stereo_voice_mix_soft_clip_core #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [svmsc_pkg::SAMPLE_W-1:0]  left_sample,
  input  logic signed [svmsc_pkg::SAMPLE_W-1:0]  right_sample,
  input  logic [svmsc_pkg::GAIN_W-1:0]           left_level,
  input  logic [svmsc_pkg::GAIN_W-1:0]           right_level,
  input  logic                                   last,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [svmsc_pkg::SAMPLE_W-1:0]  left_out,
  output logic signed [svmsc_pkg::SAMPLE_W-1:0]  right_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [svmsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [svmsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Widest shifted product of a 16-bit sample and a 9-bit gain.
  localparam int CONTRIB_W = svmsc_pkg::PROD_W - 1 - GAIN_FRAC_BITS;
  localparam int QW        = 2 * CONTRIB_W + 1;
  localparam int Q_DEPTH   = 4;

  svmsc_pkg::cfg_t         cfg;
  svmsc_pkg::q_status_t    q_stat;
  svmsc_pkg::back_status_t bk_stat;
  logic                    q_wr_en;
  logic [QW-1:0]           q_wr_data;
  logic                    q_rd_en;
  logic [QW-1:0]           q_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_threshold <= svmsc_pkg::THRESH_RESET;
      cfg.mute           <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        svmsc_pkg::CFG_CLIP_THRESHOLD: cfg.clip_threshold <= cfg_data[svmsc_pkg::THRESH_W-1:0];
        svmsc_pkg::CFG_MUTE:           cfg.mute           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  svmsc_front #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .CONTRIB_W     (CONTRIB_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .left_sample (left_sample),
    .right_sample(right_sample),
    .left_level  (left_level),
    .right_level (right_level),
    .last        (last),
    .q_stat      (q_stat),
    .q_wr_en     (q_wr_en),
    .q_wr_data   (q_wr_data)
  );

  svmsc_fifo #(
    .WIDTH(QW),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr_en),
    .wr_data(q_wr_data),
    .rd_en  (q_rd_en),
    .rd_data(q_rd_data),
    .stat   (q_stat)
  );

  svmsc_back #(
    .CONTRIB_W(CONTRIB_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .q_rd_data(q_rd_data),
    .q_rd_en  (q_rd_en),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_out (left_out),
    .right_out(right_out),
    .stat     (bk_stat)
  );

  // The front end only stalls when the queue cannot take its product.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_stat.full)
    else $error("input stalled while the queue had room");

  // A new output transaction always comes from a captured frame.
  a_out_from_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(bk_stat.frame_valid))
    else $error("output raised without a pending frame");

  // Reset leaves an empty pipeline and cleared accumulators.
  a_reset_clean: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && !bk_stat.frame_valid && bk_stat.accum_zero && q_stat.empty)
    else $error("pipeline not clean after reset");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for stereo_voice_mix_soft_clip_core.
// Depends on svmsc_pkg and the core; holds its own mixer model and drives all three channels.
module tb;

  localparam int SAMPLE_W   = svmsc_pkg::SAMPLE_W;
  localparam int GAIN_W     = svmsc_pkg::GAIN_W;
  localparam int PROD_W     = svmsc_pkg::PROD_W;
  localparam int ACC_W      = svmsc_pkg::ACC_W;
  localparam int THRESH_W   = svmsc_pkg::THRESH_W;
  localparam int CFG_IDX_W  = svmsc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = svmsc_pkg::CFG_DATA_W;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int LIMIT_CYCLES   = 500000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int SAT_VOICES     = 50;
  localparam int RAND_SEGMENTS  = 6;
  localparam int SEG_VOICES     = 140;

  localparam logic [CFG_IDX_W-1:0]       CFG_UNUSED = 8'd7;
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX    = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN    = 16'sh8000;
  localparam logic [GAIN_W-1:0]          GAIN_UNITY = 9'd256;
  localparam logic [GAIN_W-1:0]          GAIN_TOP   = 9'h1FF;
  localparam logic [THRESH_W-1:0]        THR_TOP    = 15'h7FFF;
  localparam logic signed [33:0]         ACC_MAX    = 34'sd2147483647;
  localparam logic signed [33:0]         ACC_MIN    = -34'sd2147483648;
  localparam logic signed [33:0]         OUT_MAX    = 34'sd32767;
  localparam logic signed [33:0]         OUT_MIN    = -34'sd32768;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [GAIN_W-1:0]          left_level;
    logic [GAIN_W-1:0]          right_level;
    logic                       last;
    int unsigned                gap;
  } voice_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] left_sample = '0;
  logic signed [SAMPLE_W-1:0] right_sample = '0;
  logic [GAIN_W-1:0]          left_level = '0;
  logic [GAIN_W-1:0]          right_level = '0;
  logic                       last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  voice_t voices_pending[$];
  frame_t frames_due[$];

  // Model state: the two running sums and the register copies.
  logic signed [ACC_W-1:0] acc_left;
  logic signed [ACC_W-1:0] acc_right;
  logic [THRESH_W-1:0]     cur_threshold;
  logic                    cur_mute;

  int unsigned in_gap_max = 0;
  int unsigned out_stall_max = 0;
  int unsigned gap_left = 0;
  bit          gap_armed = 1'b0;
  int unsigned stall_left = 0;
  int          voices_sent = 0;
  int          frames_checked = 0;
  int          reg_writes = 0;
  int          mismatch_cnt = 0;
  int          cycles = 0;

  stereo_voice_mix_soft_clip_core #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .left_sample(left_sample),
    .right_sample(right_sample),
    .left_level(left_level),
    .right_level(right_level),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_out(left_out),
    .right_out(right_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d frames outstanding", cycles, frames_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Scaled voice contribution; the arithmetic shift rounds toward minus infinity.
  function automatic logic signed [PROD_W-1:0] scaled_voice(
    input logic signed [SAMPLE_W-1:0] smp,
    input logic [GAIN_W-1:0]          gain
  );
    logic signed [PROD_W-1:0] prod;
    prod = smp * $signed({1'b0, gain});
    return prod >>> GAIN_FRAC_BITS;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_accumulate(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] add
  );
    logic signed [33:0] sum;
    sum = acc + add;
    if (sum > ACC_MAX) return ACC_MAX[ACC_W-1:0];
    if (sum < ACC_MIN) return ACC_MIN[ACC_W-1:0];
    return sum[ACC_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip_expected(
    input logic signed [ACC_W-1:0] acc,
    input logic [THRESH_W-1:0]     thr
  );
    logic signed [33:0] s;
    logic signed [33:0] t;
    s = acc;
    t = $signed({19'd0, thr});
    if (s > t) begin
      s = t + ((s - t) >>> 2);
    end else if (s < -t) begin
      s = -(t + ((-s - t) >>> 2));
    end
    if (s > OUT_MAX) return SMP_MAX;
    if (s < OUT_MIN) return SMP_MIN;
    return s[SAMPLE_W-1:0];
  endfunction

  // Mixer model: follows every accepted voice and register write.
  always @(posedge clk) begin
    frame_t f;
    if (rst) begin
      acc_left = '0;
      acc_right = '0;
      cur_threshold = svmsc_pkg::THRESH_RESET;
      cur_mute = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          svmsc_pkg::CFG_CLIP_THRESHOLD: cur_threshold = cfg_data[THRESH_W-1:0];
          svmsc_pkg::CFG_MUTE:           cur_mute = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        voices_sent++;
        acc_left = sat_accumulate(acc_left, scaled_voice(left_sample, left_level));
        acc_right = sat_accumulate(acc_right, scaled_voice(right_sample, right_level));
        if (last) begin
          f.left = cur_mute ? '0 : clip_expected(acc_left, cur_threshold);
          f.right = cur_mute ? '0 : clip_expected(acc_right, cur_threshold);
          frames_due.push_back(f);
          acc_left = '0;
          acc_right = '0;
        end
      end
    end
  end

  // Voice driver: each transaction waits out its own drawn gap first.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_armed = 1'b0;
    end else if (!in_valid || in_ready) begin
      if (voices_pending.size() != 0 && !gap_armed) begin
        gap_left = voices_pending[0].gap;
        gap_armed = 1'b1;
      end
      if (voices_pending.size() != 0 && gap_left == 0) begin
        left_sample <= voices_pending[0].left_sample;
        right_sample <= voices_pending[0].right_sample;
        left_level <= voices_pending[0].left_level;
        right_level <= voices_pending[0].right_level;
        last <= voices_pending[0].last;
        void'(voices_pending.pop_front());
        gap_armed = 1'b0;
        in_valid <= 1'b1;
      end else begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end
    end
  end

  // Frame monitor and output back-pressure.
  always @(posedge clk) begin
    frame_t exp_f;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("Unexpected frame L=%0d R=%0d", left_out, right_out);
          mismatch_cnt++;
        end else begin
          exp_f = frames_due.pop_front();
          if (left_out !== exp_f.left || right_out !== exp_f.right) begin
            if (mismatch_cnt < 10)
              $display("Frame %0d mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                       frames_checked, exp_f.left, exp_f.right, left_out, right_out);
            mismatch_cnt++;
          end
          frames_checked++;
        end
        stall_left = $urandom_range(0, out_stall_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void queue_voice(
    input logic signed [SAMPLE_W-1:0] ls,
    input logic signed [SAMPLE_W-1:0] rs,
    input logic [GAIN_W-1:0]          lg,
    input logic [GAIN_W-1:0]          rg,
    input logic                       lst
  );
    voice_t v;
    v.left_sample = ls;
    v.right_sample = rs;
    v.left_level = lg;
    v.right_level = rg;
    v.last = lst;
    v.gap = $urandom_range(0, in_gap_max);
    voices_pending.push_back(v);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return 16'($urandom_range(0, 15));
      3: return 16'($urandom_range(65520, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return GAIN_UNITY;
      1: return '0;
      2: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(0, 256));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    #1;
  endtask

  // Upper data bits are random so that register masking is exercised too.
  task automatic set_threshold(input logic [THRESH_W-1:0] thr);
    write_reg(svmsc_pkg::CFG_CLIP_THRESHOLD, {1'($urandom), thr});
  endtask

  task automatic set_mute(input logic m);
    write_reg(svmsc_pkg::CFG_MUTE, {15'($urandom), m});
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (voices_pending.size() != 0 || in_valid || frames_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    #1;
  endtask

  initial begin
    int seg_gap[RAND_SEGMENTS]   = '{17, 0, 5, 17, 2, 17};
    int seg_stall[RAND_SEGMENTS] = '{17, 0, 17, 3, 0, 17};
    int frame_left;
    logic [THRESH_W-1:0] thr;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    #1;

    // Directed voices at the reset settings.
    in_gap_max = 3;
    out_stall_max = 3;
    queue_voice(SMP_MAX, SMP_MIN, GAIN_UNITY, GAIN_UNITY, 1'b1);
    // Negative products round toward minus infinity.
    queue_voice(-16'sd1, 16'sd1, 9'd1, 9'd255, 1'b0);
    queue_voice(-16'sd1, 16'sd1, 9'd1, 9'd255, 1'b0);
    queue_voice(-16'sd1, 16'sd1, 9'd1, 9'd255, 1'b1);
    queue_voice(SMP_MAX, SMP_MAX, GAIN_TOP, 9'd0, 1'b1);
    queue_voice(16'sd0, 16'sd0, 9'd0, 9'd0, 1'b1);
    queue_voice(16'sd12345, -16'sd12345, GAIN_UNITY, GAIN_UNITY, 1'b0);
    queue_voice(-16'sd12345, 16'sd12345, GAIN_UNITY, GAIN_UNITY, 1'b1);
    repeat (2) queue_voice(SMP_MAX, SMP_MIN, GAIN_TOP, GAIN_TOP, 1'b0);
    queue_voice(SMP_MAX, SMP_MIN, GAIN_TOP, GAIN_TOP, 1'b1);
    wait_drained();

    // With a zero threshold every nonzero sum is compressed.
    set_threshold('0);
    queue_voice(16'sd5, -16'sd5, GAIN_UNITY, GAIN_UNITY, 1'b1);
    queue_voice(16'sd3, -16'sd3, GAIN_UNITY, GAIN_UNITY, 1'b1);
    queue_voice(SMP_MIN, SMP_MAX, GAIN_UNITY, GAIN_UNITY, 1'b1);
    wait_drained();

    set_threshold(THR_TOP);
    queue_voice(SMP_MAX, SMP_MIN, GAIN_UNITY, GAIN_UNITY, 1'b0);
    queue_voice(SMP_MAX, SMP_MIN, GAIN_UNITY, GAIN_UNITY, 1'b1);
    wait_drained();

    // Muted frames still accumulate and clear; mute is lifted in mid-frame.
    set_mute(1'b1);
    queue_voice(16'sd1000, 16'sd1000, GAIN_UNITY, GAIN_UNITY, 1'b0);
    queue_voice(16'sd2000, -16'sd2000, 9'd300, 9'd300, 1'b1);
    queue_voice(16'sd30000, 16'sd30000, GAIN_UNITY, GAIN_UNITY, 1'b0);
    wait_drained();
    set_mute(1'b0);
    queue_voice(16'sd100, -16'sd100, GAIN_UNITY, GAIN_UNITY, 1'b1);
    wait_drained();

    // One long back-to-back frame drives both sums far past the output range.
    set_threshold(svmsc_pkg::THRESH_RESET);
    in_gap_max = 0;
    out_stall_max = 0;
    for (int i = 0; i < SAT_VOICES; i++)
      queue_voice(SMP_MAX, SMP_MIN, GAIN_TOP, GAIN_TOP, 1'b0);
    queue_voice(SMP_MIN, SMP_MAX, GAIN_UNITY, GAIN_UNITY, 1'b1);
    wait_drained();
    write_reg(CFG_UNUSED, 16'($urandom));

    // Random frames; segment edges may fall inside a frame.
    frame_left = 0;
    for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
      case (seg)
        1:       thr = '0;
        2:       thr = THR_TOP;
        3:       thr = 15'($urandom_range(0, 2000));
        5:       thr = svmsc_pkg::THRESH_RESET;
        default: thr = 15'($urandom);
      endcase
      set_threshold(thr);
      set_mute(seg == 3);
      in_gap_max = seg_gap[seg];
      out_stall_max = seg_stall[seg];
      for (int n = 0; n < SEG_VOICES; n++) begin
        if (frame_left == 0)
          frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 6);
        frame_left--;
        queue_voice(pick_sample(), pick_sample(), pick_gain(), pick_gain(), frame_left == 0);
      end
      wait_drained();
    end

    $display("Run covered %0d voices in %0d checked frames with %0d register writes,",
             voices_sent, frames_checked, reg_writes);
    $display("including zero and full thresholds, muting and clamped sums.");
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/svmsc_pkg.sv
src/svmsc_front.sv
src/svmsc_fifo.sv
src/svmsc_back.sv
src/stereo_voice_mix_soft_clip_core.sv
dv/tb.sv
